@@ rtl/core/atfb_pkg.sv @@
`default_nettype none
package atfb_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] NET_HI     = 8'hFF;
  localparam logic [7:0] NET_LO     = 8'hFE;
  localparam logic [7:0] LEN_OFFSET = 8'd14;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  typedef enum logic [2:0] {
    REG_DEST_ADDRESS   = 3'd0,
    REG_FRAME_TYPE     = 3'd1,
    REG_FRAME_ID       = 3'd2,
    REG_HOP_RADIUS     = 3'd3,
    REG_OPTION_BITS    = 3'd4,
    REG_PAYLOAD_LENGTH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] dest_address;
    logic [7:0]  frame_type;
    logic [7:0]  frame_id;
    logic [7:0]  hop_radius;
    logic [7:0]  option_bits;
    logic [7:0]  payload_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] eff_length(input logic [7:0] len);
    eff_length = (len == 8'd0) ? 8'd1 : len;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/atfb_if.sv @@
`default_nettype none
interface atfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  modport source(output valid, output payload_byte, input ready);
  modport sink(input valid, input payload_byte, output ready);
endinterface

interface atfb_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;
  modport source(output valid, output tx_byte, output frame_end, input ready);
  modport sink(input valid, input tx_byte, input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atfb_cfg_regs.sv @@
`default_nettype none
module atfb_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [atfb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [atfb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [atfb_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output atfb_pkg::cfg_t                     cfg
);
  import atfb_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_address   <= 64'h0000_0000_0000_FFFF;
      cfg.frame_type     <= 8'h10;
      cfg.frame_id       <= 8'h00;
      cfg.hop_radius     <= 8'h00;
      cfg.option_bits    <= 8'h00;
      cfg.payload_length <= 8'h01;
    end else if (wr) begin
      case (idx)
        REG_DEST_ADDRESS:   cfg.dest_address   <= pwdata;
        REG_FRAME_TYPE:     cfg.frame_type     <= pwdata[7:0];
        REG_FRAME_ID:       cfg.frame_id       <= pwdata[7:0];
        REG_HOP_RADIUS:     cfg.hop_radius     <= pwdata[7:0];
        REG_OPTION_BITS:    cfg.option_bits    <= pwdata[7:0];
        REG_PAYLOAD_LENGTH: cfg.payload_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DEST_ADDRESS:   prdata = cfg.dest_address;
      REG_FRAME_TYPE:     prdata = {56'd0, cfg.frame_type};
      REG_FRAME_ID:       prdata = {56'd0, cfg.frame_id};
      REG_HOP_RADIUS:     prdata = {56'd0, cfg.hop_radius};
      REG_OPTION_BITS:    prdata = {56'd0, cfg.option_bits};
      REG_PAYLOAD_LENGTH: prdata = {56'd0, cfg.payload_length};
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/atfb_front.sv @@
`default_nettype none
module atfb_front (
  input  wire logic                clk,
  input  wire logic                rst,
  atfb_byte_if.sink                payload,
  input  wire logic [7:0]          payload_length,
  input  wire logic                q_full,
  output logic                     push,
  output atfb_pkg::entry_t         push_entry
);
  import atfb_pkg::*;

  logic [7:0] payload_count;
  logic [7:0] payload_count_next;
  logic [8:0] count_inc;

  assign payload.ready = ~q_full;
  assign push          = payload.valid & payload.ready;
  assign count_inc     = {1'b0, payload_count} + 9'd1;

  assign push_entry.payload_byte = payload.payload_byte;
  assign push_entry.first        = (payload_count == 8'd0);
  assign push_entry.last         = (count_inc >= {1'b0, eff_length(payload_length)});

  assign payload_count_next = push_entry.last ? 8'd0 : count_inc[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= 8'd0;
    end else if (push) begin
      payload_count <= payload_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/atfb_queue.sv @@
`default_nettype none
module atfb_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire atfb_pkg::entry_t    push_entry,
  input  wire logic                pop,
  output atfb_pkg::entry_t         head,
  output atfb_pkg::q_status_t      status
);
  import atfb_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == (QAW+1)'(QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/atfb_back.sv @@
`default_nettype none
module atfb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire atfb_pkg::cfg_t     cfg,
  input  wire atfb_pkg::entry_t   head,
  input  wire logic               head_valid,
  output logic                    pop,
  atfb_tx_if.source               tx
);
  import atfb_pkg::*;

  localparam logic [4:0] HDR_SOF     = 5'd0;
  localparam logic [4:0] HDR_LEN_HI  = 5'd1;
  localparam logic [4:0] HDR_LEN_LO  = 5'd2;
  localparam logic [4:0] HDR_TYPE    = 5'd3;
  localparam logic [4:0] HDR_ID      = 5'd4;
  localparam logic [4:0] HDR_ADDR    = 5'd5;
  localparam logic [4:0] HDR_ADDR_LS = 5'd12;
  localparam logic [4:0] HDR_NET_HI  = 5'd13;
  localparam logic [4:0] HDR_NET_LO  = 5'd14;
  localparam logic [4:0] HDR_RADIUS  = 5'd15;
  localparam logic [4:0] HDR_OPTIONS = 5'd16;
  localparam logic [4:0] STEP_DATA   = 5'd17;
  localparam logic [4:0] STEP_CSUM   = 5'd18;

  logic [4:0] step;
  logic       started;
  logic [4:0] cur_step;
  logic [2:0] addr_off;
  logic [2:0] addr_shift;
  logic [7:0] byte_out;
  logic [7:0] running_sum;
  logic       emit;
  logic       done;

  assign cur_step   = started ? step : (head.first ? HDR_SOF : STEP_DATA);
  assign addr_off   = cur_step[2:0] - HDR_ADDR[2:0];
  assign addr_shift = ~addr_off;

  always_comb begin
    byte_out = 8'h00;
    case (cur_step) inside
      HDR_SOF:                byte_out = SOF_BYTE;
      HDR_LEN_HI:             byte_out = LEN_HI;
      HDR_LEN_LO:             byte_out = LEN_OFFSET + eff_length(cfg.payload_length);
      HDR_TYPE:               byte_out = cfg.frame_type;
      HDR_ID:                 byte_out = cfg.frame_id;
      [HDR_ADDR:HDR_ADDR_LS]: byte_out = 8'(cfg.dest_address >> {addr_shift, 3'b000});
      HDR_NET_HI:             byte_out = NET_HI;
      HDR_NET_LO:             byte_out = NET_LO;
      HDR_RADIUS:             byte_out = cfg.hop_radius;
      HDR_OPTIONS:            byte_out = cfg.option_bits;
      STEP_DATA:              byte_out = head.payload_byte;
      STEP_CSUM:              byte_out = ~running_sum;
      default:                byte_out = 8'h00;
    endcase
  end

  assign emit = head_valid & (~tx.valid | tx.ready);
  assign done = ((cur_step == STEP_DATA) & ~head.last) | (cur_step == STEP_CSUM);
  assign pop  = emit & done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= HDR_SOF;
      started  <= 1'b0;
      tx.valid <= 1'b0;
    end else begin
      if (emit) begin
        started <= ~done;
        step    <= cur_step + 5'd1;
      end
      if (emit) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx.tx_byte   <= byte_out;
      tx.frame_end <= (cur_step == STEP_CSUM);
      if (cur_step == HDR_TYPE) begin
        running_sum <= byte_out;
      end else if (cur_step > HDR_TYPE && cur_step <= STEP_DATA) begin
        running_sum <= running_sum + byte_out;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/api_tx_frame_builder_unit.sv @@
// API transmit frame builder. Payload bytes enter on the payload channel and
// leave on the tx channel wrapped in transmit request frames of payload_length
// bytes each (0 acts as 1): the first byte of a frame brings out the 17-byte
// header ahead of it, the last one is followed by the checksum, flagged with
// frame_end. The output sequencer moves one byte per cycle while the tx
// channel is ready and the queue holds an entry; a 4-entry queue lets input
// keep flowing during header bursts.
// Registers (APB, 8-byte stride): dest_address, frame_type, frame_id,
// hop_radius, option_bits, payload_length; write them only while idle.
`default_nettype none
module api_tx_frame_builder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  atfb_byte_if.sink                          payload,
  atfb_tx_if.source                          tx,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [atfb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [atfb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [atfb_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import atfb_pkg::*;

  cfg_t      cfg;
  entry_t    push_entry;
  entry_t    head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  atfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  atfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .payload        (payload),
    .payload_length (cfg.payload_length),
    .q_full         (q_status.full),
    .push           (push),
    .push_entry     (push_entry)
  );

  atfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  atfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (~q_status.empty),
    .pop        (pop),
    .tx         (tx)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue read while empty");

  a_end_after_pop: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.frame_end && !$past(tx.valid && !tx.ready)) |-> $past(pop))
    else $error("checksum transfer without entry retirement");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !tx.valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

@@ bench/tb_api_tx_frame_builder_unit.sv @@
`timescale 1ns / 100ps
module tb_api_tx_frame_builder_unit;
  import atfb_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RANDOM_ITEMS   = 370;
  localparam logic [7:0]  CHECKSUM_BASE  = 8'hFF;

  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
  } tx_beat_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  atfb_byte_if payload_ch ();
  atfb_tx_if   tx_ch ();

  api_tx_frame_builder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload_ch),
    .tx      (tx_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t       model_cfg;
  logic [7:0] frame_count;
  logic [7:0] frame_sum;
  tx_beat_t   expected_tx_q[$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned payload_sent;
  int unsigned tx_checked;
  int unsigned frames_closed;
  int unsigned reg_writes;

  int unsigned burst_left;
  bit          src_gaps;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned mode_left;
  rx_mode_t    stall_mode;
  logic [7:0]  rx_pattern;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void queue_tx(input logic [7:0] b, input logic last,
                                   input logic summed);
    tx_beat_t beat;
    beat.tx_byte   = b;
    beat.frame_end = last;
    expected_tx_q.push_back(beat);
    if (summed) frame_sum = frame_sum + b;
  endfunction

  function automatic void frame_payload_byte(input logic [7:0] b);
    logic [7:0] len;
    len = (model_cfg.payload_length == 8'd0) ? 8'd1 : model_cfg.payload_length;
    if (frame_count == 8'd0) begin
      frame_sum = 8'd0;
      queue_tx(SOF_BYTE, 1'b0, 1'b0);
      queue_tx(LEN_HI, 1'b0, 1'b0);
      queue_tx(LEN_OFFSET + len, 1'b0, 1'b0);
      queue_tx(model_cfg.frame_type, 1'b0, 1'b1);
      queue_tx(model_cfg.frame_id, 1'b0, 1'b1);
      for (int k = 7; k >= 0; k--)
        queue_tx(model_cfg.dest_address[8*k +: 8], 1'b0, 1'b1);
      queue_tx(NET_HI, 1'b0, 1'b1);
      queue_tx(NET_LO, 1'b0, 1'b1);
      queue_tx(model_cfg.hop_radius, 1'b0, 1'b1);
      queue_tx(model_cfg.option_bits, 1'b0, 1'b1);
    end
    queue_tx(b, 1'b0, 1'b1);
    if ({1'b0, frame_count} + 9'd1 >= {1'b0, len}) begin
      queue_tx(CHECKSUM_BASE - frame_sum, 1'b1, 1'b0);
      frame_count = 8'd0;
      frame_sum   = 8'd0;
    end else begin
      frame_count = frame_count + 8'd1;
    end
  endfunction

  // ---------------------------------------------------------------- tx checker
  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (expected_tx_q.size() == 0) begin
        $error("tx_byte: unexpected transfer %02h (frame_end %0b)",
               tx_ch.tx_byte, tx_ch.frame_end);
        fail_count++;
      end else begin
        if (tx_ch.tx_byte !== expected_tx_q[0].tx_byte) begin
          $error("tx_byte: expected %02h, actual %02h",
                 expected_tx_q[0].tx_byte, tx_ch.tx_byte);
          fail_count++;
        end
        if (tx_ch.frame_end !== expected_tx_q[0].frame_end) begin
          $error("frame_end: expected %0b, actual %0b",
                 expected_tx_q[0].frame_end, tx_ch.frame_end);
          fail_count++;
        end
        if (expected_tx_q[0].frame_end) frames_closed++;
        void'(expected_tx_q.pop_front());
        tx_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- tx stalls
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      tx_ch.ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 128);
      end
      mode_left--;
      case (stall_mode)
        RX_STREAM: tx_ch.ready = 1'b1;
        RX_RANDOM: tx_ch.ready = ($urandom_range(0, 3) != 0);
        default: begin
          rx_pattern  = {rx_pattern[6:0], rx_pattern[7]};
          tx_ch.ready = rx_pattern[0];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_payload(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (src_gaps) begin
        gap = $urandom_range(1, 6);
        payload_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    payload_ch.valid        = 1'b1;
    payload_ch.payload_byte = b;
    do @(posedge clk); while (!payload_ch.ready);
    frame_payload_byte(b);
    payload_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    payload_ch.valid = 1'b0;
    while (expected_tx_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DEST_ADDRESS:   model_cfg.dest_address   = val;
      REG_FRAME_TYPE:     model_cfg.frame_type     = val[7:0];
      REG_FRAME_ID:       model_cfg.frame_id       = val[7:0];
      REG_HOP_RADIUS:     model_cfg.hop_radius     = val[7:0];
      REG_OPTION_BITS:    model_cfg.option_bits    = val[7:0];
      REG_PAYLOAD_LENGTH: model_cfg.payload_length = val[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic reg_read_check(input reg_idx_t idx);
    logic [63:0] got;
    logic [63:0] want;
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = {idx, 3'b000};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_DEST_ADDRESS:   want = model_cfg.dest_address;
      REG_FRAME_TYPE:     want = {56'd0, model_cfg.frame_type};
      REG_FRAME_ID:       want = {56'd0, model_cfg.frame_id};
      REG_HOP_RADIUS:     want = {56'd0, model_cfg.hop_radius};
      REG_OPTION_BITS:    want = {56'd0, model_cfg.option_bits};
      default:            want = {56'd0, model_cfg.payload_length};
    endcase
    if (idx != REG_DEST_ADDRESS) got = {56'd0, got[7:0]};
    if (got !== want) begin
      $error("%s: expected %016h, actual %016h", idx.name(), want, got);
      fail_count++;
    end
  endtask

  task automatic read_all_regs();
    reg_read_check(REG_DEST_ADDRESS);
    reg_read_check(REG_FRAME_TYPE);
    reg_read_check(REG_FRAME_ID);
    reg_read_check(REG_HOP_RADIUS);
    reg_read_check(REG_OPTION_BITS);
    reg_read_check(REG_PAYLOAD_LENGTH);
  endtask

  function automatic logic [7:0] rand_field_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_values();
    read_all_regs();
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    wait_idle();
  endtask

  task automatic test_header_fields();
    reg_write(REG_DEST_ADDRESS, 64'h0);
    reg_write(REG_FRAME_TYPE, 64'h00);
    reg_write(REG_FRAME_ID, 64'h00);
    reg_write(REG_HOP_RADIUS, 64'h00);
    reg_write(REG_OPTION_BITS, 64'h00);
    reg_write(REG_PAYLOAD_LENGTH, 64'd2);
    read_all_regs();
    send_payload(8'h00);
    send_payload(8'hFF);
    wait_idle();
    reg_write(REG_DEST_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_FRAME_TYPE, 64'hFF);
    reg_write(REG_FRAME_ID, 64'hFF);
    reg_write(REG_HOP_RADIUS, 64'hFF);
    reg_write(REG_OPTION_BITS, 64'hFF);
    read_all_regs();
    send_payload(8'hFF);
    send_payload(8'h00);
    wait_idle();
    // distinct address bytes expose byte order
    reg_write(REG_DEST_ADDRESS, 64'h0123_4567_89AB_CDEF);
    reg_write(REG_FRAME_TYPE, 64'h10);
    reg_write(REG_FRAME_ID, 64'h5C);
    reg_write(REG_HOP_RADIUS, 64'h03);
    reg_write(REG_OPTION_BITS, 64'hA1);
    read_all_regs();
    send_payload(8'h80);
    send_payload(8'h01);
    wait_idle();
  endtask

  task automatic test_zero_length();
    reg_write(REG_PAYLOAD_LENGTH, 64'd0);
    reg_read_check(REG_PAYLOAD_LENGTH);
    send_payload(8'hA5);
    send_payload(8'h5A);
    wait_idle();
  endtask

  // open a frame at a long length, then cut it short
  task automatic test_length_wrap();
    reg_write(REG_PAYLOAD_LENGTH, 64'd241);
    send_payload(8'h3C);
    wait_idle();
    reg_write(REG_PAYLOAD_LENGTH, 64'd1);
    send_payload(8'hC3);
    wait_idle();
    reg_write(REG_PAYLOAD_LENGTH, 64'd255);
    send_payload(8'h7E);
    wait_idle();
    reg_write(REG_PAYLOAD_LENGTH, 64'd2);
    send_payload(8'h81);
    wait_idle();
    reg_write(REG_PAYLOAD_LENGTH, 64'd242);
    send_payload(8'hFE);
    wait_idle();
    reg_write(REG_PAYLOAD_LENGTH, 64'd0);
    send_payload(8'h01);
    wait_idle();
  endtask

  task automatic test_config_mid_frame();
    reg_write(REG_PAYLOAD_LENGTH, 64'd4);
    send_payload(8'h11);
    send_payload(8'h22);
    wait_idle();
    reg_write(REG_FRAME_ID, 64'h99);
    reg_write(REG_DEST_ADDRESS, 64'hDEAD_0000_BEEF_0000);
    send_payload(8'h33);
    send_payload(8'h44);
    wait_idle();
  endtask

  task automatic test_backpressure();
    reg_write(REG_PAYLOAD_LENGTH, 64'd20);
    src_gaps     = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 40; i++) send_payload(8'($urandom_range(0, 255)));
    wait_idle();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned count;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) != 0) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) reg_write(REG_DEST_ADDRESS, 64'h0);
        else if (pick == 1) reg_write(REG_DEST_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
        else reg_write(REG_DEST_ADDRESS, {$urandom, $urandom});
      end
      if ($urandom_range(0, 1) != 0) reg_write(REG_FRAME_TYPE, 64'(rand_field_byte()));
      if ($urandom_range(0, 1) != 0) reg_write(REG_FRAME_ID, 64'(rand_field_byte()));
      if ($urandom_range(0, 1) != 0) reg_write(REG_HOP_RADIUS, 64'(rand_field_byte()));
      if ($urandom_range(0, 1) != 0) reg_write(REG_OPTION_BITS, 64'(rand_field_byte()));
      pick = $urandom_range(0, 19);
      if (pick == 0) reg_write(REG_PAYLOAD_LENGTH, 64'd0);
      else if (pick < 12) reg_write(REG_PAYLOAD_LENGTH, 64'($urandom_range(1, 6)));
      else if (pick < 19) reg_write(REG_PAYLOAD_LENGTH, 64'($urandom_range(7, 24)));
      else reg_write(REG_PAYLOAD_LENGTH, 64'($urandom_range(40, 70)));
      src_gaps = ($urandom_range(0, 3) != 0);
      count    = $urandom_range(5, 40);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_payload(8'h00);
        else if (pick == 1) send_payload(8'hFF);
        else send_payload(8'($urandom_range(0, 255)));
      end
      sent += count;
      wait_idle();
    end
    src_gaps = 1'b1;
  endtask

  initial begin
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    payload_ch.valid        = 1'b0;
    payload_ch.payload_byte = 8'h00;
    tx_ch.ready             = 1'b0;
    rx_pattern              = 8'b1011_0110;
    src_gaps                = 1'b1;
    model_cfg.dest_address   = 64'hFFFF;
    model_cfg.frame_type     = 8'h10;
    model_cfg.frame_id       = 8'h00;
    model_cfg.hop_radius     = 8'h00;
    model_cfg.option_bits    = 8'h00;
    model_cfg.payload_length = 8'd1;
    frame_count = 8'd0;
    frame_sum   = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_header_fields();
    test_zero_length();
    test_length_wrap();
    test_config_mid_frame();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d payload transfers, %0d tx transfers in %0d frames,",
             payload_sent, tx_checked, frames_closed);
    $display("%0d register writes incl. zero, wrapping and mid-frame length changes.",
             reg_writes);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
